// ----- rtl/core/mme_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mme_pkg: shared types and constants of the matrix multiply engine
// sizes, fixed-point format, command and register codes, transaction structs
// ----------------------------------------------------------------------------
package mme_pkg;

  // matrix geometry
  localparam int unsigned MAX_SIDE = 8;
  localparam int unsigned IDX_W    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int unsigned ADDR_W   = 2 * IDX_W;
  localparam int unsigned DEPTH    = MAX_SIDE * MAX_SIDE;
  localparam int unsigned DIM_W    = 4;

  // fixed-point format
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned ACC_W     = PROD_W + $clog2(MAX_SIDE + 1) + 1;

  // configuration port
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LHS_ROWS   = 2'd0,
    CFG_INNER_SIZE = 2'd1,
    CFG_RHS_COLS   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_LOAD_LEFT  = 2'd0,
    CMD_LOAD_RIGHT = 2'd1,
    CMD_COMPUTE    = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]              command;
    logic [2:0]              elem_row;
    logic [2:0]              elem_col;
    logic signed [DATA_W-1:0] elem_value;
  } mme_in_t;

  typedef struct packed {
    logic [2:0]              out_row;
    logic [2:0]              out_col;
    logic signed [DATA_W-1:0] out_value;
    logic                    out_last;
  } mme_out_t;

  // sequencer to multiply-accumulate unit
  typedef struct packed {
    logic clr;    // zero the accumulator
    logic issue;  // operand read issued this cycle
  } mme_mac_ctrl_t;

  typedef struct packed {
    logic busy;   // products still in flight
  } mme_mac_stat_t;

endpackage : mme_pkg
`default_nettype wire

// ----- rtl/core/mme_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mme_ram: element store
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module mme_ram
  import mme_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [ADDR_W-1:0]        waddr_i,
  input  wire logic signed [DATA_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0]        raddr_i,
  output logic signed [DATA_W-1:0]      rdata_o
);

  logic signed [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule : mme_ram
`default_nettype wire

// ----- rtl/core/mme_mac.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mme_mac: shared multiply-accumulate unit
// registered 32x32 product, wide accumulator, shift and saturate on output
// ----------------------------------------------------------------------------
module mme_mac
  import mme_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire mme_mac_ctrl_t            ctrl_i,
  input  wire logic signed [DATA_W-1:0] a_i,
  input  wire logic signed [DATA_W-1:0] b_i,
  output mme_mac_stat_t                 stat_o,
  output logic signed [DATA_W-1:0]      result_o
);

  logic                     rd_vld_q;
  logic                     prod_vld_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_d;
  logic signed [ACC_W-1:0]  shifted;
  logic                     ovf;

  // read data arrives in the cycle after the issue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      rd_vld_q   <= ctrl_i.issue;
      prod_vld_q <= rd_vld_q;
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      prod_q <= a_i * b_i;
    end
    acc_q <= acc_d;
  end

  // floor shift, then clamp to the 32-bit range
  assign shifted = acc_q >>> FRAC_BITS;
  assign ovf     = ~((&shifted[ACC_W-1:DATA_W-1]) | ~(|shifted[ACC_W-1:DATA_W-1]));

  always_comb begin
    if (ovf) begin
      result_o = shifted[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                  : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      result_o = shifted[DATA_W-1:0];
    end
  end

  assign stat_o.busy = rd_vld_q | prod_vld_q;

endmodule : mme_mac
`default_nettype wire

// ----- rtl/core/matrix_multiply_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_multiply_engine: signed Q16.16 dense matrix product C = A x B
// loads elements of A and B, computes and streams C in row-major order
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_stall_o, payload in_data_i) carries one
//   command per transaction: load a left element, load a right element, or
//   compute. a load produces nothing; loads outside the configured dimensions
//   are dropped. a compute emits rows x cols result transactions on the output
//   channel (out_valid_o / out_stall_i), the final one with out_last set.
//   each result element is built in order: operand reads through the single
//   shared multiplier, a drain of the store read, product and accumulate
//   registers, and a load of the output register; with a zero inner size the
//   operand reads are skipped.
//   the input is stalled for the whole compute.
//   the output register holds a result until the receiver takes it; while it
//   is full and out_stall_i is high the sequencer waits in its emit step.
//   configuration (cfg_we_i, cfg_idx_i, cfg_data_i) is for the user to write
//   only while idle; the block does not enforce it. dimensions above the maximum
//   side act as the maximum. reset returns to idle, sets all dimensions to 8
//   and empties the output register; the element stores are not cleared.
// ----------------------------------------------------------------------------
module matrix_multiply_engine
  import mme_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [DIM_W-1:0]     cfg_data_i,
  // input channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire mme_in_t              in_data_i,
  // output channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output mme_out_t                  out_data_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_EMIT
  } state_e;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    return (v > DIM_W'(MAX_SIDE)) ? DIM_W'(MAX_SIDE) : v;
  endfunction

  // dimension registers
  logic [DIM_W-1:0] lhs_rows_q, inner_size_q, rhs_cols_q;
  logic [DIM_W-1:0] nr, ni, nc;

  // sequencer
  state_e           state_q;
  logic [IDX_W-1:0] row_q, col_q, k_q;
  logic             out_vld_q;
  mme_out_t         out_q;

  logic             in_acc;
  logic             out_take;
  logic             out_free;
  logic             row_ok, col_ok;
  logic             is_last_col, is_last_row, is_last_k;
  logic             left_we, right_we;
  logic [ADDR_W-1:0] load_addr;
  logic [ADDR_W-1:0] left_raddr, right_raddr;
  logic signed [DATA_W-1:0] left_rdata, right_rdata;
  logic signed [DATA_W-1:0] mac_result;
  mme_mac_ctrl_t    mac_ctrl;
  mme_mac_stat_t    mac_stat;

  assign nr = eff_dim(lhs_rows_q);
  assign ni = eff_dim(inner_size_q);
  assign nc = eff_dim(rhs_cols_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lhs_rows_q   <= DIM_W'(8);
      inner_size_q <= DIM_W'(8);
      rhs_cols_q   <= DIM_W'(8);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LHS_ROWS:   lhs_rows_q   <= cfg_data_i;
        CFG_INNER_SIZE: inner_size_q <= cfg_data_i;
        CFG_RHS_COLS:   rhs_cols_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshakes
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign out_take    = out_vld_q && !out_stall_i;
  assign out_free    = !out_vld_q || out_take;

  // load decode: range depends on which matrix is written
  always_comb begin
    row_ok   = 1'b0;
    col_ok   = 1'b0;
    left_we  = 1'b0;
    right_we = 1'b0;
    unique case (in_data_i.command)
      CMD_LOAD_LEFT: begin
        row_ok  = DIM_W'(in_data_i.elem_row) < nr;
        col_ok  = DIM_W'(in_data_i.elem_col) < ni;
        left_we = in_acc && row_ok && col_ok;
      end
      CMD_LOAD_RIGHT: begin
        row_ok   = DIM_W'(in_data_i.elem_row) < ni;
        col_ok   = DIM_W'(in_data_i.elem_col) < nc;
        right_we = in_acc && row_ok && col_ok;
      end
      default: ;
    endcase
  end

  assign load_addr   = {in_data_i.elem_row[IDX_W-1:0], in_data_i.elem_col[IDX_W-1:0]};
  assign left_raddr  = {row_q, k_q};
  assign right_raddr = {k_q, col_q};

  assign is_last_k   = (DIM_W'(k_q) + DIM_W'(1)) == ni;
  assign is_last_col = (DIM_W'(col_q) + DIM_W'(1)) == nc;
  assign is_last_row = (DIM_W'(row_q) + DIM_W'(1)) == nr;

  // accumulator cleared whenever a new element starts
  always_comb begin
    mac_ctrl.issue = (state_q == S_ISSUE);
    mac_ctrl.clr   = 1'b0;
    if (state_q == S_IDLE) begin
      mac_ctrl.clr = 1'b1;
    end else if (state_q == S_EMIT && out_free) begin
      mac_ctrl.clr = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      row_q     <= '0;
      col_q     <= '0;
      k_q       <= '0;
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else begin
      // a new result wins over the take of the previous one
      if (state_q == S_EMIT && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_take) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && in_data_i.command == CMD_COMPUTE
              && nr != '0 && nc != '0) begin
            row_q   <= '0;
            col_q   <= '0;
            k_q     <= '0;
            state_q <= (ni == '0) ? S_DRAIN : S_ISSUE;
          end
        end
        S_ISSUE: begin
          // one operand pair a cycle into the shared multiplier
          if (is_last_k) begin
            k_q     <= '0;
            state_q <= S_DRAIN;
          end else begin
            k_q <= k_q + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          if (!mac_stat.busy && !mac_ctrl.issue) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_q.out_row     <= 3'(row_q);
            out_q.out_col     <= 3'(col_q);
            out_q.out_value   <= mac_result;
            out_q.out_last    <= is_last_row && is_last_col;
            if (is_last_col) begin
              col_q <= '0;
              if (is_last_row) begin
                state_q <= S_IDLE;
              end else begin
                row_q   <= row_q + IDX_W'(1);
                state_q <= (ni == '0) ? S_DRAIN : S_ISSUE;
              end
            end else begin
              col_q   <= col_q + IDX_W'(1);
              state_q <= (ni == '0) ? S_DRAIN : S_ISSUE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  mme_ram u_left_store (
    .clk_i   (clk_i),
    .we_i    (left_we),
    .waddr_i (load_addr),
    .wdata_i (in_data_i.elem_value),
    .raddr_i (left_raddr),
    .rdata_o (left_rdata)
  );

  mme_ram u_right_store (
    .clk_i   (clk_i),
    .we_i    (right_we),
    .waddr_i (load_addr),
    .wdata_i (in_data_i.elem_value),
    .raddr_i (right_raddr),
    .rdata_o (right_rdata)
  );

  mme_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .a_i      (left_rdata),
    .b_i      (right_rdata),
    .stat_o   (mac_stat),
    .result_o (mac_result)
  );

endmodule : matrix_multiply_engine
`default_nettype wire

// ----- test/matrix_multiply_engine_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_engine_tb: self-checking bench for the matrix multiply engine
// streams load and compute transactions with random gaps and output stalls,
// predicts every Q16.16 product element and checks each one as it leaves
// ----------------------------------------------------------------------------
module matrix_multiply_engine_tb;
  import mme_pkg::*;

  // command code that the engine has no use for
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 24;
  localparam int IDLE_PCT     = 28;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 227;

  // saturation bounds of the signed 32-bit result
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  // clock, reset and block inputs, all known from time zero
  logic           clk_i;
  logic           rst_ni      = 1'b0;
  logic           cfg_we_i    = 1'b0;
  cfg_idx_e       cfg_idx_i   = CFG_LHS_ROWS;
  logic [DIM_W-1:0] cfg_data_i = '0;
  logic           in_valid_i  = 1'b0;
  logic           in_stall_o;
  mme_in_t        in_data_i   = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  mme_out_t       out_data_o;

  // shadow of the engine: element stores and dimension registers
  logic signed [DATA_W-1:0] lhs_mem [DEPTH];
  logic signed [DATA_W-1:0] rhs_mem [DEPTH];
  logic [DIM_W-1:0]         rows_cfg  = 4'd8;
  logic [DIM_W-1:0]         inner_cfg = 4'd8;
  logic [DIM_W-1:0]         cols_cfg  = 4'd8;

  // product elements still to come out of the engine, oldest first
  mme_out_t product_queue[$];

  int  error_count = 0;
  int  cycle_count = 0;
  int  result_count = 0;
  bit  idle_off = 1'b0;      // no gaps on either side while set
  int  hold_reqs = 0;        // bumped by a test to start a long output hold
  int  hold_seen = 0;
  int  hold_left = 0;

  matrix_multiply_engine uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // run-away guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  // dimension registers above the maximum side act as the maximum
  function automatic int side_of(logic [DIM_W-1:0] v);
    return (v > MAX_SIDE) ? MAX_SIDE : int'(v);
  endfunction

  // one result element: full-width products, wide sum, floor shift, saturate
  function automatic logic signed [DATA_W-1:0] mac_element(int r, int c, int n);
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  scaled;
    acc = '0;
    for (int k = 0; k < n; k++) begin
      prod = lhs_mem[r * MAX_SIDE + k] * rhs_mem[k * MAX_SIDE + c];
      acc  = acc + prod;
    end
    scaled = acc >>> FRAC_BITS;
    if (scaled > Q_MAX) return 32'h7fff_ffff;
    if (scaled < Q_MIN) return 32'h8000_0000;
    return scaled[DATA_W-1:0];
  endfunction

  // true when a load lands in a store under the current dimensions
  function automatic bit load_hits(mme_in_t t);
    int nr, ni, nc;
    nr = side_of(rows_cfg);
    ni = side_of(inner_cfg);
    nc = side_of(cols_cfg);
    case (t.command)
      CMD_LOAD_LEFT:  return (t.elem_row < nr) && (t.elem_col < ni);
      CMD_LOAD_RIGHT: return (t.elem_row < ni) && (t.elem_col < nc);
      default:        return 1'b0;
    endcase
  endfunction

  // apply one accepted transaction to the shadow and queue its products
  function automatic void absorb_command(mme_in_t t);
    mme_out_t e;
    int nr, ni, nc;
    nr = side_of(rows_cfg);
    ni = side_of(inner_cfg);
    nc = side_of(cols_cfg);
    case (t.command)
      CMD_LOAD_LEFT: begin
        if (load_hits(t)) lhs_mem[t.elem_row * MAX_SIDE + t.elem_col] = t.elem_value;
      end
      CMD_LOAD_RIGHT: begin
        if (load_hits(t)) rhs_mem[t.elem_row * MAX_SIDE + t.elem_col] = t.elem_value;
      end
      CMD_COMPUTE: begin
        for (int i = 0; i < nr; i++) begin
          for (int j = 0; j < nc; j++) begin
            e.out_row   = 3'(i);
            e.out_col   = 3'(j);
            e.out_value = mac_element(i, j, ni);
            e.out_last  = (i == nr - 1) && (j == nc - 1);
            product_queue.push_back(e);
          end
        end
      end
      default: ;  // unused command, nothing happens
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus

  // Q16.16 values: mostly small so sums stay in range, some extremes
  function automatic logic signed [DATA_W-1:0] rand_q16();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom;
      default: return 32'($urandom_range(0, 32'h0003_ffff)) - 32'h0002_0000;
    endcase
  endfunction

  function automatic mme_in_t make_item(logic [1:0] cmd, int row, int col,
                                        logic signed [DATA_W-1:0] value);
    mme_in_t t;
    t.command    = cmd;
    t.elem_row   = 3'(row);
    t.elem_col   = 3'(col);
    t.elem_value = value;
    return t;
  endfunction

  // compute transaction with junk in the unused fields
  function automatic mme_in_t compute_item();
    return make_item(CMD_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
  endfunction

  // index mostly inside the bound, sometimes anywhere
  function automatic int pick_index(int bound);
    if (bound > 0 && $urandom_range(0, 99) < 80) return $urandom_range(0, bound - 1);
    return $urandom_range(0, 7);
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int p;
    p = $urandom_range(0, 99);
    if (p < 6)  return 4'd0;
    if (p < 70) return 4'($urandom_range(1, 4));
    if (p < 85) return 4'($urandom_range(5, 8));
    return 4'($urandom_range(9, 15));
  endfunction

  // send one transaction; called and returns at a falling edge, leaves valid high
  task automatic push_command(mme_in_t t);
    while (!idle_off && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (in_stall_o);
    absorb_command(t);
    @(negedge clk_i);
  endtask

  // stop sending, wait for every product, then let the engine settle
  task automatic drain_engine();
    in_valid_i <= 1'b0;
    while (product_queue.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // write all three dimension registers on consecutive cycles, engine idle
  task automatic set_dims(logic [DIM_W-1:0] r, logic [DIM_W-1:0] i,
                          logic [DIM_W-1:0] c);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_LHS_ROWS;
    cfg_data_i <= r;
    rows_cfg   = r;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_INNER_SIZE;
    cfg_data_i <= i;
    inner_cfg  = i;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_RHS_COLS;
    cfg_data_i <= c;
    cols_cfg   = c;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // ---------------------------------------------------------------- receiver

  // random output stalls, plus a long hold whenever a test asks for one
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_reqs != hold_seen) begin
      hold_seen   <= hold_reqs;
      hold_left   <= HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !idle_off && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  task automatic report_mismatch(string field, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
    error_count++;
    $display("mismatch on result %0d, %s: got %h, expected %h",
             result_count, field, got, want);
  endtask

  // compare every accepted output transaction with the oldest prediction
  always @(posedge clk_i) begin : check_results
    mme_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (product_queue.size() == 0) begin
        report_mismatch("unexpected result", DATA_W'(out_data_o.out_value), '0);
      end else begin
        want = product_queue.pop_front();
        if (out_data_o.out_row !== want.out_row)
          report_mismatch("out_row", DATA_W'(out_data_o.out_row), DATA_W'(want.out_row));
        if (out_data_o.out_col !== want.out_col)
          report_mismatch("out_col", DATA_W'(out_data_o.out_col), DATA_W'(want.out_col));
        if (out_data_o.out_value !== want.out_value)
          report_mismatch("out_value", out_data_o.out_value, want.out_value);
        if (out_data_o.out_last !== want.out_last)
          report_mismatch("out_last", DATA_W'(out_data_o.out_last),
                          DATA_W'(want.out_last));
      end
      result_count++;
    end
  end

  // ---------------------------------------------------------------- tests

  // write every entry of both stores so no compute ever reads an unwritten one
  task automatic test_fill_stores();
    for (int r = 0; r < MAX_SIDE; r++) begin
      for (int c = 0; c < MAX_SIDE; c++) begin
        push_command(make_item(CMD_LOAD_LEFT, r, c, rand_q16()));
        push_command(make_item(CMD_LOAD_RIGHT, r, c, rand_q16()));
      end
    end
    drain_engine();
  endtask

  // saturation both ways and floor rounding of negative fractions, 1x1x1
  task automatic test_fixed_point_extremes();
    set_dims(4'd1, 4'd1, 4'd1);
    push_command(make_item(CMD_LOAD_LEFT, 0, 0, 32'h7fff_ffff));
    push_command(make_item(CMD_LOAD_RIGHT, 0, 0, 32'h7fff_ffff));
    push_command(compute_item());
    push_command(make_item(CMD_LOAD_RIGHT, 0, 0, 32'h8000_0000));
    push_command(compute_item());
    push_command(make_item(CMD_LOAD_LEFT, 0, 0, 32'h8000_0000));
    push_command(compute_item());
    // -1 lsb times +1 lsb rounds down to -1 lsb
    push_command(make_item(CMD_LOAD_LEFT, 0, 0, 32'hffff_ffff));
    push_command(make_item(CMD_LOAD_RIGHT, 0, 0, 32'h0000_0001));
    push_command(compute_item());
    // 1.5 times -1.0
    push_command(make_item(CMD_LOAD_LEFT, 0, 0, 32'h0001_8000));
    push_command(make_item(CMD_LOAD_RIGHT, 0, 0, 32'hffff_0000));
    push_command(compute_item());
    drain_engine();
  endtask

  // largest indices at full size, then oversized registers acting as 8
  task automatic test_full_size();
    set_dims(4'd8, 4'd8, 4'd8);
    push_command(make_item(CMD_LOAD_LEFT, 7, 7, 32'h0002_0000));
    push_command(make_item(CMD_LOAD_RIGHT, 7, 7, 32'hfffe_0000));
    push_command(compute_item());
    drain_engine();
    set_dims(4'd15, 4'd15, 4'd15);
    push_command(compute_item());
    drain_engine();
  endtask

  // zero rows or zero columns give nothing, zero inner size gives zeros
  task automatic test_zero_dims();
    set_dims(4'd0, 4'd3, 4'd3);
    push_command(make_item(CMD_LOAD_LEFT, 0, 0, 32'h1234_5678));
    push_command(compute_item());
    drain_engine();
    set_dims(4'd3, 4'd3, 4'd0);
    push_command(compute_item());
    drain_engine();
    set_dims(4'd2, 4'd0, 4'd3);
    push_command(compute_item());
    drain_engine();
  endtask

  // loads past the current dimensions are dropped
  task automatic test_out_of_range();
    set_dims(4'd2, 4'd3, 4'd2);
    push_command(make_item(CMD_LOAD_LEFT, 2, 0, 32'h7fff_ffff));
    push_command(make_item(CMD_LOAD_LEFT, 0, 3, 32'h7fff_ffff));
    push_command(make_item(CMD_LOAD_RIGHT, 3, 0, 32'h8000_0000));
    push_command(make_item(CMD_LOAD_RIGHT, 0, 2, 32'h8000_0000));
    push_command(make_item(CMD_LOAD_LEFT, 1, 2, 32'h0000_8000));
    push_command(compute_item());
    drain_engine();
  endtask

  // command 3 must change nothing and emit nothing
  task automatic test_unused_command();
    push_command(make_item(CMD_UNUSED, 1, 1, 32'hdead_beef));
    push_command(compute_item());
    drain_engine();
  endtask

  // receiver holds off for a long stretch while loads queue up behind a compute
  task automatic test_backpressure();
    set_dims(4'd4, 4'd4, 4'd4);
    hold_reqs++;
    push_command(compute_item());
    repeat (8) push_command(make_item(2'($urandom_range(0, 1)), $urandom_range(0, 3),
                                      $urandom_range(0, 3), rand_q16()));
    push_command(compute_item());
    drain_engine();
  endtask

  // back-to-back traffic with no gaps and no stalls at all
  task automatic test_quiet_stream();
    idle_off = 1'b1;
    set_dims(4'd3, 4'd5, 4'd4);
    repeat (10) push_command(make_item(2'($urandom_range(0, 1)), $urandom_range(0, 4),
                                       $urandom_range(0, 4), rand_q16()));
    push_command(compute_item());
    repeat (4) push_command(make_item(2'($urandom_range(0, 1)), $urandom_range(0, 2),
                                      $urandom_range(0, 3), rand_q16()));
    push_command(compute_item());
    drain_engine();
    idle_off = 1'b0;
  endtask

  // random dimensions, a burst of mostly in-range loads, then one or two computes
  task automatic test_random_products();
    int counted, nr, ni, nc, p;
    mme_in_t t;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      set_dims(pick_dim(), pick_dim(), pick_dim());
      nr = side_of(rows_cfg);
      ni = side_of(inner_cfg);
      nc = side_of(cols_cfg);
      repeat ($urandom_range(2, 14)) begin
        p = $urandom_range(0, 99);
        if (p < 46)
          t = make_item(CMD_LOAD_LEFT, pick_index(nr), pick_index(ni), rand_q16());
        else if (p < 92)
          t = make_item(CMD_LOAD_RIGHT, pick_index(ni), pick_index(nc), rand_q16());
        else
          t = make_item(CMD_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
        counted++;
        push_command(t);
      end
      repeat ($urandom_range(1, 2)) begin
        push_command(compute_item());
        counted++;
      end
      drain_engine();
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    test_fill_stores();
    test_fixed_point_extremes();
    test_full_size();
    test_zero_dims();
    test_out_of_range();
    test_unused_command();
    test_backpressure();
    test_quiet_stream();
    test_random_products();

    drain_engine();
    if (product_queue.size() != 0)
      report_mismatch("missing results", DATA_W'(product_queue.size()), '0);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
